// File: rtl/core/dqn_pkg.sv
// Shared types and constants for the DNS query name extractor.
package dqn_pkg;

  localparam int NAME_MAX_DEFAULT = 254;
  localparam int QUEUE_DEPTH      = 4;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  // Work left for the back end by one frame byte: a name byte, a verdict, or both.
  typedef struct packed {
    logic       has_name;
    logic [7:0] name_char;
    logic [7:0] name_pos;
    logic       has_verdict;
    logic       is_candidate;
    logic [7:0] name_length;
  } dqn_entry_t;

endpackage

// File: rtl/core/dns_query_name_extractor.sv
// Top level of the DNS query name extractor.
//
//  channel   direction  handshake               payload
//  frame in  input      push / full             frame_byte, frame_end
//  results   output     empty / pop             result_kind, name_char, name_position,
//                                               is_candidate, name_length, run_last
//  config    input      cfg_write               cfg_data (dns_port)
//
// One frame byte is accepted per cycle while full is low; results leave one per
// cycle while they are popped. A result reaches the result ports through the
// queue write and then the result register; the parser itself is combinational.
// A last name byte and its frame verdict share one queue entry and leave as two
// results, name byte first. Reset (rst, synchronous) clears the parser, queue and
// result stage and sets dns_port to 53. full rises only when the
// four-entry queue fills while results are not popped.
module dns_query_name_extractor import dqn_pkg::*; #(
  parameter int NAME_MAX_BYTES = NAME_MAX_DEFAULT,
  parameter int DEPTH          = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [7:0]  name_char,
  output logic [7:0]  name_position,
  output logic        is_candidate,
  output logic [7:0]  name_length,
  output logic        run_last,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  dqn_entry_t f_entry, q_data;
  logic       f_push, q_empty, q_pop, accept;

  assign accept = push && !full;

  dqn_front #(.NAME_MAX_BYTES(NAME_MAX_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .entry_push (f_push),
    .entry      (f_entry)
  );

  dqn_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_entry),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  dqn_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .name_char     (name_char),
    .name_position (name_position),
    .is_candidate  (is_candidate),
    .name_length   (name_length),
    .run_last      (run_last)
  );

endmodule

// File: rtl/core/dqn_front.sv
// Front end: frame byte parser, header checks and query name normalization.
module dqn_front import dqn_pkg::*; #(
  parameter int NAME_MAX_BYTES = NAME_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output logic        entry_push,
  output dqn_entry_t  entry
);

  typedef enum logic [1:0] {IP_NONE, IP_V4, IP_V6} ip_sel_t;

  localparam logic [8:0] OFF_MAX      = 9'd511;
  localparam logic [8:0] OFF_TYPE_HI  = 9'd12;
  localparam logic [8:0] OFF_TYPE_LO  = 9'd13;
  localparam logic [8:0] OFF_IP_START = 9'd14;
  localparam logic [8:0] V4_UDP_BASE  = 9'd34;
  localparam logic [8:0] V6_UDP_BASE  = 9'd54;
  localparam logic [8:0] V4_PROTO_OFF = 9'd23;
  localparam logic [8:0] V6_PROTO_OFF = 9'd20;
  localparam logic [8:0] V4_MIN_LAST  = 9'd59;
  localparam logic [8:0] V6_MIN_LAST  = 9'd79;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] LABEL_MAX    = 8'd63;
  localparam logic [7:0] DOT_CHAR     = 8'd46;
  localparam logic [7:0] NAME_MAX     = 8'(NAME_MAX_BYTES);

  logic [15:0] dns_port;
  logic [8:0]  byte_offset, byte_offset_next;
  logic [7:0]  ether_hi, ether_hi_next;
  ip_sel_t     ip_sel, ip_sel_next;
  logic        udp_seen, udp_seen_next;
  logic [15:0] dest_port, dest_port_next;
  logic        response_bit, response_bit_next;
  logic        q_nonzero, q_nonzero_next;
  logic [5:0]  label_rem, label_rem_next;
  logic [7:0]  name_count, name_count_next;
  logic        name_finished, name_finished_next;

  logic [8:0]  udp_base, proto_off, min_last;
  logic        in_ip, hdr_ok, name_active, emit, cand;
  logic [7:0]  out_char;

  always_comb begin
    byte_offset_next   = byte_offset;
    ether_hi_next      = ether_hi;
    ip_sel_next        = ip_sel;
    udp_seen_next      = udp_seen;
    dest_port_next     = dest_port;
    response_bit_next  = response_bit;
    q_nonzero_next     = q_nonzero;
    label_rem_next     = label_rem;
    name_count_next    = name_count;
    name_finished_next = name_finished;
    emit               = 1'b0;
    out_char           = DOT_CHAR;

    if (byte_offset == OFF_TYPE_HI) begin
      ether_hi_next = frame_byte;
    end else if (byte_offset == OFF_TYPE_LO) begin
      if ({ether_hi, frame_byte} == 16'h0800) begin
        ip_sel_next = IP_V4;
      end else if ({ether_hi, frame_byte} == 16'h86DD) begin
        ip_sel_next = IP_V6;
      end else begin
        ip_sel_next = IP_NONE;
      end
    end

    unique case (ip_sel)
      IP_V4: begin
        udp_base  = V4_UDP_BASE;
        proto_off = V4_PROTO_OFF;
      end
      IP_V6: begin
        udp_base  = V6_UDP_BASE;
        proto_off = V6_PROTO_OFF;
      end
      default: begin
        udp_base  = '0;
        proto_off = '0;
      end
    endcase

    in_ip  = (ip_sel != IP_NONE) && (byte_offset >= OFF_IP_START);
    hdr_ok = udp_seen && (dest_port == dns_port) && !response_bit && q_nonzero;

    if (in_ip) begin
      if (byte_offset == proto_off) begin
        udp_seen_next = (frame_byte == PROTO_UDP);
      end else if (byte_offset == udp_base + 9'd2) begin
        dest_port_next = {frame_byte, 8'h00};
      end else if (byte_offset == udp_base + 9'd3) begin
        dest_port_next = {dest_port[15:8], frame_byte};
      end else if (byte_offset == udp_base + 9'd10) begin
        response_bit_next = frame_byte[7];
      end else if ((byte_offset == udp_base + 9'd12 || byte_offset == udp_base + 9'd13)
                   && frame_byte != 8'd0) begin
        q_nonzero_next = 1'b1;
      end
    end

    name_active = in_ip && (byte_offset >= udp_base + 9'd20) && !name_finished && hdr_ok;
    if (name_active) begin
      if (name_count >= NAME_MAX) begin
        name_finished_next = 1'b1;
      end else if (label_rem == 6'd0) begin
        if (frame_byte == 8'd0 || frame_byte > LABEL_MAX) begin
          name_finished_next = 1'b1;
        end else begin
          label_rem_next  = frame_byte[5:0];
          emit            = 1'b1;
          out_char        = DOT_CHAR;
          name_count_next = name_count + 8'd1;
        end
      end else begin
        out_char        = (frame_byte >= 8'h41 && frame_byte <= 8'h5A) ?
                          frame_byte + 8'd32 : frame_byte;
        label_rem_next  = label_rem - 6'd1;
        emit            = 1'b1;
        name_count_next = name_count + 8'd1;
      end
      if (name_count_next >= NAME_MAX) begin
        name_finished_next = 1'b1;
      end
    end

    min_last = (ip_sel_next == IP_V4) ? V4_MIN_LAST : V6_MIN_LAST;
    cand = (ip_sel_next != IP_NONE) && hdr_ok && (byte_offset >= min_last);

    entry.has_name     = emit;
    entry.name_char    = out_char;
    entry.name_pos     = name_count;
    entry.has_verdict  = frame_end;
    entry.is_candidate = cand;
    entry.name_length  = name_count_next;
    entry_push         = accept && (emit || frame_end);

    if (frame_end) begin
      byte_offset_next   = '0;
      ether_hi_next      = '0;
      ip_sel_next        = IP_NONE;
      udp_seen_next      = 1'b0;
      dest_port_next     = '0;
      response_bit_next  = 1'b0;
      q_nonzero_next     = 1'b0;
      label_rem_next     = '0;
      name_count_next    = '0;
      name_finished_next = 1'b0;
    end else if (byte_offset != OFF_MAX) begin
      byte_offset_next = byte_offset + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port      <= DNS_PORT_RESET;
      byte_offset   <= '0;
      ether_hi      <= '0;
      ip_sel        <= IP_NONE;
      udp_seen      <= 1'b0;
      dest_port     <= '0;
      response_bit  <= 1'b0;
      q_nonzero     <= 1'b0;
      label_rem     <= '0;
      name_count    <= '0;
      name_finished <= 1'b0;
    end else begin
      if (cfg_write) begin
        dns_port <= cfg_data;
      end
      if (accept) begin
        byte_offset   <= byte_offset_next;
        ether_hi      <= ether_hi_next;
        ip_sel        <= ip_sel_next;
        udp_seen      <= udp_seen_next;
        dest_port     <= dest_port_next;
        response_bit  <= response_bit_next;
        q_nonzero     <= q_nonzero_next;
        label_rem     <= label_rem_next;
        name_count    <= name_count_next;
        name_finished <= name_finished_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_name_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (entry_push && entry.has_name) |-> (entry.name_pos < NAME_MAX))
    else $error("name byte emitted past the name limit");
`endif

endmodule

// File: rtl/core/dqn_fifo.sv
// Short register queue between the parser and the result stage.
module dqn_fifo import dqn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  dqn_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output dqn_entry_t pop_data,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dqn_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// File: rtl/core/dqn_back.sv
// Back end: turns queued entries into name byte and verdict results.
module dqn_back import dqn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  dqn_entry_t q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind,
  output logic [7:0] name_char,
  output logic [7:0] name_position,
  output logic       is_candidate,
  output logic [7:0] name_length,
  output logic       run_last
);

  dqn_entry_t cur;
  logic       cur_valid;
  logic       taken, split, done, load;

  assign empty = !cur_valid;
  assign taken = pop && cur_valid;
  // name byte and verdict share one entry: show the name byte first
  assign split = cur.has_name && cur.has_verdict;
  assign done  = taken && !split;
  assign load  = !cur_valid || done;
  assign q_pop = load && !q_empty;

  always_comb begin
    if (cur.has_name) begin
      result_kind   = 1'b0;
      name_char     = cur.name_char;
      name_position = cur.name_pos;
      is_candidate  = 1'b0;
      name_length   = 8'd0;
      run_last      = 1'b0;
    end else begin
      result_kind   = 1'b1;
      name_char     = 8'd0;
      name_position = 8'd0;
      is_candidate  = cur.is_candidate;
      name_length   = cur.name_length;
      run_last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end else if (taken && split) begin
      cur.has_name <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= !q_empty;
    end
  end

`ifndef ASSERT_OFF
  a_entry_has_work: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.has_name || cur.has_verdict))
    else $error("held entry carries no result");
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    (taken && split) |=> (cur_valid && result_kind && run_last))
    else $error("verdict lost after its name byte");
`endif

endmodule
